// File: sv/btc_pkg.sv
package btc_pkg;

  localparam int COL_W       = 8;
  localparam int MAX_COL_DEF = 255;
  localparam int TAB_WIDTH   = 8;
  localparam int CMD_DEPTH   = 4;

  localparam logic [7:0] CHR_TAB = 8'd9;
  localparam logic [7:0] CHR_NL  = 8'd10;
  localparam logic [7:0] CHR_SP  = 8'd32;

  localparam logic REQ_CHAR  = 1'b0;
  localparam logic REQ_FLUSH = 1'b1;

  typedef struct packed {
    logic       req_type;
    logic [7:0] ch;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       last;
  } out_item_t;

  // Work for the back end: emit the gap from column w to column t as tabs
  // and spaces, then the byte if has_byte is set.
  typedef struct packed {
    logic [COL_W-1:0] w;
    logic [COL_W-1:0] t;
    logic             has_byte;
    logic [7:0]       data;
  } cmd_t;

  // Next tab stop after col, one bit wider so it cannot wrap.
  function automatic logic [COL_W:0] next_stop(input logic [COL_W-1:0] col);
    logic [COL_W:0] sum;
    sum = {1'b0, col} + (COL_W+1)'(TAB_WIDTH);
    return sum & ~((COL_W+1)'(TAB_WIDTH - 1));
  endfunction

endpackage

// File: sv/blank_run_to_tab_converter.sv
// Channel  Direction  Handshake            Payload
// input    in         push / full          in_item  (req_type, ch)
// result   out        empty / pop          out_item (out_byte, last)
// config   in         cfg_we               cfg_wdata (mode_all)
//
// A byte that passes through, or that ends a run of white space, is taken
// whenever the command queue has room; each result item leaves one per cycle
// while the output slot is free, and a byte ending a gap leaves as its tabs
// and spaces, then itself; blanks and tabs outside a copied line produce nothing.
// The back end's emit loop sets the output rate; the queue holds up to CMD_DEPTH
// commands behind the one being expanded, and the input stalls only while it is full.
// Reset is synchronous on rst_n and clears the columns, mode and queues.
module blank_run_to_tab_converter #(
  parameter int MAX_COL   = btc_pkg::MAX_COL_DEF,
  parameter int CMD_DEPTH = btc_pkg::CMD_DEPTH
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  output logic               full,
  input  btc_pkg::in_item_t  in_item,
  output logic               empty,
  input  logic               pop,
  output btc_pkg::out_item_t out_item,
  input  logic               cfg_we,
  input  logic               cfg_wdata
);

  // The conversion mode register. The user must write it only while the block is
  // idle, so the front end can use it directly; the block itself does not enforce it.
  logic mode_all_r;

  logic          accept;
  logic          cmd_push;
  btc_pkg::cmd_t cmd_in;
  btc_pkg::cmd_t cmd_out;
  logic          cmd_pop;
  logic          cmd_empty;

  // An item is accepted whenever the command queue has room, even when this
  // item turns out to need no command.
  assign accept = push && !full;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_all_r <= 1'b0;
    end else if (cfg_we) begin
      mode_all_r <= cfg_wdata;
    end
  end

  // The front end keeps the written and target columns, decides what each
  // byte means and turns a flush into a command when a gap is pending.
  btc_front #(
    .MAX_COL (MAX_COL)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .mode_all (mode_all_r),
    .accept   (accept),
    .item     (in_item),
    .cmd_push (cmd_push),
    .cmd      (cmd_in)
  );

  btc_fifo #(
    .DEPTH (CMD_DEPTH)
  ) u_fifo (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (cmd_push),
    .wdata (cmd_in),
    .pop   (cmd_pop),
    .rdata (cmd_out),
    .full  (full),
    .empty (cmd_empty)
  );

  // The back end expands each command into tabs, spaces and any byte, one
  // result item per cycle while the registered output slot is free.
  btc_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd_out),
    .cmd_empty (cmd_empty),
    .cmd_pop   (cmd_pop),
    .out_item  (out_item),
    .empty     (empty),
    .pop       (pop)
  );

endmodule

// File: sv/btc_front.sv
module btc_front #(
  parameter int MAX_COL = btc_pkg::MAX_COL_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             mode_all,
  input  logic             accept,
  input  btc_pkg::in_item_t item,
  output logic             cmd_push,
  output btc_pkg::cmd_t    cmd
);

  localparam int CW = btc_pkg::COL_W;
  localparam logic [CW:0] MAX_W = (CW+1)'(MAX_COL);

  logic [CW-1:0] wcol_r, wcol_nxt;
  logic [CW-1:0] tcol_r, tcol_nxt;
  logic          pass_r, pass_nxt;

  function automatic logic [CW-1:0] sat(input logic [CW:0] v);
    return (v > MAX_W) ? MAX_W[CW-1:0] : v[CW-1:0];
  endfunction

  always_comb begin
    wcol_nxt = wcol_r;
    tcol_nxt = tcol_r;
    pass_nxt = pass_r;
    cmd_push = 1'b0;
    cmd      = '{w: wcol_r, t: tcol_r, has_byte: 1'b0, data: item.ch};
    if (accept) begin
      if (item.req_type == btc_pkg::REQ_FLUSH) begin
        cmd_push = (wcol_r != tcol_r);
        wcol_nxt = tcol_r;
      end else if (pass_r) begin
        cmd_push     = 1'b1;
        cmd.w        = '0;
        cmd.t        = '0;
        cmd.has_byte = 1'b1;
        if (item.ch == btc_pkg::CHR_NL) begin
          wcol_nxt = '0;
          tcol_nxt = '0;
          pass_nxt = 1'b0;
        end
      end else if (item.ch == btc_pkg::CHR_SP) begin
        tcol_nxt = sat({1'b0, tcol_r} + (CW+1)'(1));
      end else if (item.ch == btc_pkg::CHR_TAB) begin
        tcol_nxt = sat(btc_pkg::next_stop(tcol_r));
      end else begin
        cmd_push     = 1'b1;
        cmd.has_byte = 1'b1;
        if (item.ch == btc_pkg::CHR_NL) begin
          wcol_nxt = '0;
          tcol_nxt = '0;
          pass_nxt = 1'b0;
        end else if (!mode_all) begin
          wcol_nxt = tcol_r;
          pass_nxt = 1'b1;
        end else begin
          wcol_nxt = sat({1'b0, tcol_r} + (CW+1)'(1));
          tcol_nxt = sat({1'b0, tcol_r} + (CW+1)'(1));
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wcol_r <= '0;
      tcol_r <= '0;
      pass_r <= 1'b0;
    end else begin
      wcol_r <= wcol_nxt;
      tcol_r <= tcol_nxt;
      pass_r <= pass_nxt;
    end
  end

endmodule

// File: sv/btc_fifo.sv
module btc_fifo #(
  parameter int DEPTH = btc_pkg::CMD_DEPTH
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  btc_pkg::cmd_t wdata,
  input  logic          pop,
  output btc_pkg::cmd_t rdata,
  output logic          full,
  output logic          empty
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  btc_pkg::cmd_t mem [DEPTH];
  logic [AW-1:0] wptr_r, wptr_nxt;
  logic [AW-1:0] rptr_r, rptr_nxt;
  logic [AW:0]   count_r, count_nxt;
  logic          do_push, do_pop;

  assign full    = (count_r == (AW+1)'(DEPTH));
  assign empty   = (count_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = mem[rptr_r];

  function automatic logic [AW-1:0] inc(input logic [AW-1:0] p);
    return (p == AW'(DEPTH - 1)) ? '0 : p + AW'(1);
  endfunction

  always_comb begin
    wptr_nxt  = do_push ? inc(wptr_r) : wptr_r;
    rptr_nxt  = do_pop ? inc(rptr_r) : rptr_r;
    count_nxt = count_r + (AW+1)'(do_push) - (AW+1)'(do_pop);
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wptr_r] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r  <= '0;
      rptr_r  <= '0;
      count_r <= '0;
    end else begin
      wptr_r  <= wptr_nxt;
      rptr_r  <= rptr_nxt;
      count_r <= count_nxt;
    end
  end

endmodule

// File: sv/btc_back.sv
module btc_back (
  input  logic               clk,
  input  logic               rst_n,
  input  btc_pkg::cmd_t      cmd,
  input  logic               cmd_empty,
  output logic               cmd_pop,
  output btc_pkg::out_item_t out_item,
  output logic               empty,
  input  logic               pop
);

  localparam int CW = btc_pkg::COL_W;

  logic          cur_v_r, cur_v_nxt;
  btc_pkg::cmd_t cur_r, cur_nxt;
  btc_pkg::out_item_t out_r, out_nxt;
  logic          out_v_r, out_v_nxt;

  logic          slot_free, emit, done;
  logic [CW:0]   ns;
  logic [CW-1:0] w_plus1, w_adv;

  assign empty    = !out_v_r;
  assign out_item = out_r;

  always_comb begin
    ns        = btc_pkg::next_stop(cur_r.w);
    w_plus1   = cur_r.w + CW'(1);
    slot_free = !out_v_r || pop;
    emit      = cur_v_r && slot_free;
    out_nxt   = out_r;
    w_adv     = cur_r.w;
    done      = 1'b0;
    if ((ns <= {1'b0, cur_r.t}) && (w_plus1 != cur_r.t)) begin
      out_nxt.out_byte = btc_pkg::CHR_TAB;
      w_adv            = ns[CW-1:0];
      done             = !cur_r.has_byte && (ns[CW-1:0] == cur_r.t);
    end else if (cur_r.w < cur_r.t) begin
      out_nxt.out_byte = btc_pkg::CHR_SP;
      w_adv            = w_plus1;
      done             = !cur_r.has_byte && (w_plus1 == cur_r.t);
    end else begin
      out_nxt.out_byte = cur_r.data;
      done             = 1'b1;
    end
    out_nxt.last = done;
    if (!emit) begin
      out_nxt = out_r;
    end

    cmd_pop   = !cmd_empty && (!cur_v_r || (emit && done));
    cur_nxt   = cur_r;
    cur_v_nxt = cur_v_r;
    if (emit) begin
      cur_nxt.w = w_adv;
      if (done) begin
        cur_v_nxt = 1'b0;
      end
    end
    if (cmd_pop) begin
      cur_nxt   = cmd;
      cur_v_nxt = 1'b1;
    end

    if (emit) begin
      out_v_nxt = 1'b1;
    end else if (pop) begin
      out_v_nxt = 1'b0;
    end else begin
      out_v_nxt = out_v_r;
    end
  end

  always_ff @(posedge clk) begin
    cur_r <= cur_nxt;
    out_r <= out_nxt;
    if (!rst_n) begin
      cur_v_r <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      cur_v_r <= cur_v_nxt;
      out_v_r <= out_v_nxt;
    end
  end

endmodule

// File: bench/blank_run_to_tab_checker.sv
`timescale 1ns / 100ps

// Watches all three channels of the converter, keeps its own copy of the line
// state and compares every popped result item with the oldest predicted one.
module blank_run_to_tab_checker (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  input  logic               full,
  input  btc_pkg::in_item_t  in_item,
  input  logic               empty,
  input  logic               pop,
  input  btc_pkg::out_item_t out_item,
  input  logic               cfg_we,
  input  logic               cfg_wdata,
  output int                 fail_count,
  output int                 pending,
  output int                 results_seen
);

  localparam int MAX_COL = btc_pkg::MAX_COL_DEF;
  localparam int CW      = btc_pkg::COL_W;

  logic          mode_all_q;
  logic [CW-1:0] wcol;
  logic [CW-1:0] tcol;
  logic          copy_line;

  btc_pkg::out_item_t expected_bytes[$];
  btc_pkg::out_item_t burst[$];

  function automatic int stop_after(int c);
    return (c + btc_pkg::TAB_WIDTH) & ~(btc_pkg::TAB_WIDTH - 1);
  endfunction

  function automatic logic [CW-1:0] clamp_col(int v);
    return CW'((v > MAX_COL) ? MAX_COL : v);
  endfunction

  task automatic emit(logic [7:0] b);
    btc_pkg::out_item_t r;
    r.out_byte = b;
    r.last     = 1'b0;
    burst.push_back(r);
  endtask

  // Tabs while a whole stop fits, except that a lone blank reaching a stop
  // stays a space; the remainder goes out as spaces.
  task automatic flush_gap();
    while (stop_after(int'(wcol)) <= int'(tcol) && int'(wcol) + 1 != int'(tcol)) begin
      emit(btc_pkg::CHR_TAB);
      wcol = clamp_col(stop_after(int'(wcol)));
    end
    while (wcol < tcol) begin
      emit(btc_pkg::CHR_SP);
      wcol = clamp_col(int'(wcol) + 1);
    end
  endtask

  task automatic clear_line();
    wcol      = '0;
    tcol      = '0;
    copy_line = 1'b0;
  endtask

  task automatic predict_item(btc_pkg::in_item_t it);
    burst.delete();
    if (it.req_type == btc_pkg::REQ_FLUSH) begin
      flush_gap();
    end else if (copy_line) begin
      emit(it.ch);
      if (it.ch == btc_pkg::CHR_NL) clear_line();
    end else if (it.ch == btc_pkg::CHR_SP) begin
      tcol = clamp_col(int'(tcol) + 1);
    end else if (it.ch == btc_pkg::CHR_TAB) begin
      tcol = clamp_col(stop_after(int'(tcol)));
    end else begin
      flush_gap();
      emit(it.ch);
      if (it.ch == btc_pkg::CHR_NL) begin
        clear_line();
      end else if (!mode_all_q) begin
        copy_line = 1'b1;
      end else begin
        wcol = clamp_col(int'(wcol) + 1);
        tcol = clamp_col(int'(tcol) + 1);
      end
    end
    if (burst.size() > 0) burst[burst.size() - 1].last = 1'b1;
    foreach (burst[i]) expected_bytes.push_back(burst[i]);
  endtask

  always @(posedge clk) begin
    btc_pkg::out_item_t exp_r;
    if (!rst_n) begin
      mode_all_q = 1'b0;
      clear_line();
      expected_bytes.delete();
      fail_count   <= 0;
      results_seen <= 0;
    end else begin
      // Predict before comparing so that a same-edge bypass would still line up.
      if (push && !full) predict_item(in_item);
      if (pop && !empty) begin
        results_seen <= results_seen + 1;
        if (expected_bytes.size() == 0) begin
          $display("%0t: unexpected result, expected none, actual byte %h last %b",
                   $time, out_item.out_byte, out_item.last);
          fail_count <= fail_count + 1;
        end else begin
          exp_r = expected_bytes.pop_front();
          if (exp_r.out_byte !== out_item.out_byte || exp_r.last !== out_item.last) begin
            $display("%0t: mismatch, expected byte %h last %b, actual byte %h last %b",
                     $time, exp_r.out_byte, exp_r.last, out_item.out_byte, out_item.last);
            fail_count <= fail_count + 1;
          end
        end
      end
      // A mode write counts for the items after this edge, as in the block.
      if (cfg_we) mode_all_q = cfg_wdata;
    end
    pending <= expected_bytes.size();
  end

endmodule

// File: bench/blank_run_to_tab_converter_tb.sv
`timescale 1ns / 100ps

// Stimulus and verdict for the blank-run to tab converter. The checker beside
// the block does all prediction and comparison; this module only feeds items,
// stalls the result side, writes the mode register and reports the outcome.
module blank_run_to_tab_converter_tb;

  logic               clk;
  logic               rst_n     = 1'b0;
  logic               push      = 1'b0;
  btc_pkg::in_item_t  in_item   = '0;
  logic               pop       = 1'b0;
  logic               cfg_we    = 1'b0;
  logic               cfg_wdata = 1'b0;
  logic               full;
  logic               empty;
  btc_pkg::out_item_t out_item;

  int fail_count;
  int pending;
  int results_seen;

  // Percentages of cycles in which each side holds off.
  int send_idle = 0;
  int recv_idle = 0;
  int items_sent = 0;

  btc_pkg::in_item_t stim_q[$];

  blank_run_to_tab_converter u_top (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .full     (full),
    .in_item  (in_item),
    .empty    (empty),
    .pop      (pop),
    .out_item (out_item),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata)
  );

  blank_run_to_tab_checker u_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .push        (push),
    .full        (full),
    .in_item     (in_item),
    .empty       (empty),
    .pop         (pop),
    .out_item    (out_item),
    .cfg_we      (cfg_we),
    .cfg_wdata   (cfg_wdata),
    .fail_count  (fail_count),
    .pending     (pending),
    .results_seen(results_seen)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // The receiver decides afresh every cycle whether it takes a result.
  always @(posedge clk) begin
    pop <= ($urandom_range(99) >= recv_idle);
  end

  // Generous upper bound on the whole run; a hang ends up here.
  initial begin
    #10ms;
    $display("CHECKS FAILED");
    $finish;
  end

  function automatic btc_pkg::in_item_t char_item(logic [7:0] c);
    btc_pkg::in_item_t it;
    it.req_type = btc_pkg::REQ_CHAR;
    it.ch       = c;
    return it;
  endfunction

  // The byte that rides along with an end-of-text request is random, since
  // the block has to ignore it.
  function automatic btc_pkg::in_item_t flush_item();
    btc_pkg::in_item_t it;
    it.req_type = btc_pkg::REQ_FLUSH;
    it.ch       = 8'($urandom_range(255));
    return it;
  endfunction

  // Presents one item and holds it until it is taken. A random number of
  // idle cycles goes in front of it according to send_idle.
  task automatic send(btc_pkg::in_item_t it);
    while ($urandom_range(99) < send_idle) begin
      push <= 1'b0;
      @(posedge clk);
    end
    push    <= 1'b1;
    in_item <= it;
    do @(posedge clk); while (full);
    items_sent++;
  endtask

  task automatic run_queue();
    while (stim_q.size() > 0) send(stim_q.pop_front());
    push <= 1'b0;
  endtask

  // Stops pushing and waits until every predicted result has been popped, then
  // idles on before returning. A blank or a tab outside a copied line only moves
  // the front end's target column and never enters the command queue.
  task automatic drain();
    push <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (12) @(posedge clk);
  endtask

  task automatic write_mode(logic v);
    drain();
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  // A run of white space: mostly blanks, some tabs.
  task automatic add_blanks(int n);
    repeat (n) begin
      stim_q.push_back(char_item(($urandom_range(99) < 70) ? btc_pkg::CHR_SP
                                                           : btc_pkg::CHR_TAB));
    end
  endtask

  // A word of printable bytes; now and then a fully random byte slips in,
  // which may itself be a blank, a tab or a newline.
  task automatic add_word();
    repeat ($urandom_range(6, 1)) begin
      if ($urandom_range(99) < 15) begin
        stim_q.push_back(char_item(8'($urandom_range(255))));
      end else begin
        stim_q.push_back(char_item(8'($urandom_range(126, 33))));
      end
    end
  endtask

  // Appends one line of random text. Most lines are well formed: leading
  // white space, words with gaps between them and a newline. A few carry a
  // tab run long enough to saturate the columns, and a few are pure noise.
  task automatic add_line();
    int kind;
    kind = $urandom_range(99);
    if (kind < 6) begin
      repeat ($urandom_range(40, 30)) begin
        stim_q.push_back(char_item(($urandom_range(99) < 85) ? btc_pkg::CHR_TAB
                                                             : btc_pkg::CHR_SP));
      end
      add_word();
      add_blanks($urandom_range(3));
      if ($urandom_range(1)) stim_q.push_back(flush_item());
      add_word();
      stim_q.push_back(char_item(btc_pkg::CHR_NL));
    end else if (kind < 88) begin
      add_blanks($urandom_range(12));
      repeat ($urandom_range(4, 1)) begin
        add_word();
        add_blanks($urandom_range(10, 1));
        if ($urandom_range(99) < 10) stim_q.push_back(flush_item());
      end
      if ($urandom_range(99) < 30) add_word();
      // Some lines are left open so that the next phase starts mid-line.
      if ($urandom_range(99) < 90) stim_q.push_back(char_item(btc_pkg::CHR_NL));
    end else begin
      repeat ($urandom_range(10, 3)) begin
        if ($urandom_range(99) < 10) begin
          stim_q.push_back(flush_item());
        end else begin
          stim_q.push_back(char_item(8'($urandom_range(255))));
        end
      end
    end
  endtask

  // Builds whole lines until the phase has its items, then cuts the tail so
  // that each phase sends exactly n_items; a cut line simply stays open.
  task automatic random_phase(int s_idle, int r_idle, int n_items);
    send_idle = s_idle;
    recv_idle = r_idle;
    while (stim_q.size() < n_items) add_line();
    while (stim_q.size() > n_items) void'(stim_q.pop_back());
    run_queue();
  endtask

  initial begin
    // Synchronous reset, held at the start and never again.
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_idle = 31;
    recv_idle = 52;

    // Leading-only mode: blanks and a tab before a byte are converted, the
    // rest of the line, blanks and tabs included, is copied, and the newline
    // ends the copied line. An end-of-text request with nothing pending
    // must give no result.
    write_mode(1'b0);
    stim_q.push_back(char_item(btc_pkg::CHR_SP));
    stim_q.push_back(char_item(btc_pkg::CHR_SP));
    stim_q.push_back(char_item(btc_pkg::CHR_TAB));
    stim_q.push_back(char_item(8'h7f));
    stim_q.push_back(char_item(btc_pkg::CHR_SP));
    stim_q.push_back(char_item(btc_pkg::CHR_TAB));
    stim_q.push_back(char_item(btc_pkg::CHR_NL));
    stim_q.push_back(flush_item());
    run_queue();

    // Convert-everywhere mode: six blanks and a byte bring the written column
    // to seven, so the single blank that follows reaches a tab stop and must
    // stay a space. Then the byte extremes, a flush of pending blanks and a
    // newline with nothing pending.
    write_mode(1'b1);
    repeat (6) stim_q.push_back(char_item(btc_pkg::CHR_SP));
    stim_q.push_back(char_item(8'h00));
    stim_q.push_back(char_item(btc_pkg::CHR_SP));
    stim_q.push_back(char_item(8'hff));
    stim_q.push_back(char_item(btc_pkg::CHR_SP));
    stim_q.push_back(char_item(btc_pkg::CHR_SP));
    stim_q.push_back(flush_item());
    stim_q.push_back(char_item(btc_pkg::CHR_NL));
    run_queue();

    // Random text under three stall patterns. The mode is switched between
    // phases while a line may still be open, so a change mid-line is hit.
    random_phase(31, 52, 66);
    write_mode(1'b0);
    random_phase(52, 31, 66);
    write_mode(1'b1);
    random_phase(0, 0, 66);

    drain();
    repeat (8) @(posedge clk);

    $display("Sent %0d input items and checked %0d result items,", items_sent, results_seen);
    $display("in both modes, with stalls on either side and a stall-free stretch.");
    if (fail_count == 0 && pending == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

// File: sim.f
sv/btc_pkg.sv
sv/btc_front.sv
sv/btc_fifo.sv
sv/btc_back.sv
sv/blank_run_to_tab_converter.sv
bench/blank_run_to_tab_checker.sv
bench/blank_run_to_tab_converter_tb.sv
